// File: rtl/core/serial_frame_parser_xor_defines.svh
// ----------------------------------------------------------------------------
// Serial frame parser assertion macros
// Shared assertion helpers for the serial frame parser. Each macro samples on
// the rising edge of clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_PARSER_XOR_DEFINES_SVH
`define SERIAL_FRAME_PARSER_XOR_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never be true.
`define SFPX_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("serial frame parser: forbidden condition seen");

// The consequent must hold in the same cycle as the antecedent.
`define SFPX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("serial frame parser: implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SFPX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("serial frame parser: next-cycle implication failed");

`else

`define SFPX_ASSERT_NEVER(lbl, cond)
`define SFPX_ASSERT_IMP(lbl, ante, cons)
`define SFPX_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/sfpx_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame parser package
// Parse phases, status codes, register indexes and the payload buffer's
// read-side struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sfpx_pkg;

    localparam int BYTE_W    = 8;
    localparam int NODE_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int PIDX_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hB1;
    localparam logic [BYTE_W-1:0] CHECK_INIT_RESET = 8'h00;

    localparam logic [STATUS_W-1:0] ST_GOOD      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CHECK_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_COUNT_ERR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INIT = 1'd1;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_LEN,
        PH_NODE_HI,
        PH_NODE_LO,
        PH_EP,
        PH_CMD,
        PH_TYPE,
        PH_COUNT,
        PH_PAYLOAD,
        PH_SEQ,
        PH_CHECK
    } phase_t;

    // Read side of the payload buffer, one beat per payload byte.
    typedef struct packed {
        logic              busy;
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic [PIDX_W-1:0] index;
        logic              last;
    } pbuf_rd_t;

endpackage

`default_nettype wire

// File: rtl/core/serial_frame_parser_xor.sv
// ----------------------------------------------------------------------------
// Serial frame parser with XOR check
// Hunts for the start byte, collects one frame, checks its XOR byte and
// emits one result per payload byte, or a single status result.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle while not stalled. Header bytes
// and payload bytes are absorbed without producing results. A count byte above
// PAYLOAD_MAX, a bad check byte, or a good frame with no payload each give one
// result beat straight into the output register as the byte is taken. A good
// frame with payload reads its bytes back from a PAYLOAD_MAX-entry memory with
// one read port, one result beat per cycle while the output is not stalled;
// input stays stalled after such a check byte until the last payload byte has
// reached the output register. Any byte other than a count or check byte is
// taken, once the buffer is idle, even while a finished result waits at the
// output; count and check bytes wait until the output register can be loaded.
`default_nettype none
`include "serial_frame_parser_xor_defines.svh"

module serial_frame_parser_xor
    import sfpx_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [BYTE_W-1:0]     cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic [BYTE_W-1:0]     rx_byte,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [STATUS_W-1:0]   status,
    output      logic [BYTE_W-1:0]     frame_length,
    output      logic [NODE_W-1:0]     node_id,
    output      logic [BYTE_W-1:0]     endpoint,
    output      logic [BYTE_W-1:0]     command_id,
    output      logic [BYTE_W-1:0]     command_type,
    output      logic [BYTE_W-1:0]     payload_count,
    output      logic [BYTE_W-1:0]     sequence_number,
    output      logic [BYTE_W-1:0]     payload_byte,
    output      logic [PIDX_W-1:0]     payload_index,
    output      logic                  has_payload,
    output      logic                  last
);

    localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);
    localparam logic [BYTE_W:0] COUNT_LIMIT = (BYTE_W + 1)'(PAYLOAD_MAX);

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] check_init_reg;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] length_reg;
    logic [BYTE_W-1:0] length_next;
    logic [NODE_W-1:0] node_reg;
    logic [NODE_W-1:0] node_next;
    logic [BYTE_W-1:0] endpoint_reg;
    logic [BYTE_W-1:0] endpoint_next;
    logic [BYTE_W-1:0] command_reg;
    logic [BYTE_W-1:0] command_next;
    logic [BYTE_W-1:0] type_reg;
    logic [BYTE_W-1:0] type_next;
    logic [BYTE_W-1:0] count_reg;
    logic [BYTE_W-1:0] count_next;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  pos_next;
    logic [BYTE_W-1:0] sequence_reg;
    logic [BYTE_W-1:0] sequence_next;
    logic [BYTE_W-1:0] check_reg;
    logic [BYTE_W-1:0] check_next;

    logic              in_accept;
    logic              result_phase;
    logic              out_free;
    logic              direct_load;
    logic [STATUS_W-1:0] direct_status;
    logic              buf_wr;
    logic              buf_start;
    logic              rd_take;
    logic [CNT_W-1:0]  pos_inc;
    logic [BYTE_W-1:0] check_acc;
    pbuf_rd_t          pbuf;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [BYTE_W-1:0]   frame_length_reg;
    logic [NODE_W-1:0]   node_id_reg;
    logic [BYTE_W-1:0]   endpoint_out_reg;
    logic [BYTE_W-1:0]   command_id_reg;
    logic [BYTE_W-1:0]   command_type_reg;
    logic [BYTE_W-1:0]   payload_count_reg;
    logic [BYTE_W-1:0]   sequence_number_reg;
    logic [BYTE_W-1:0]   payload_byte_reg;
    logic [PIDX_W-1:0]   payload_index_reg;
    logic                has_payload_reg;
    logic                last_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            check_init_reg <= CHECK_INIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_BYTE: start_byte_reg <= cfg_data;
                CFG_CHECK_INIT: check_init_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Only the count and check bytes can produce a result beat, so only they
    // wait for a stalled output register.
    assign out_free     = !out_valid_reg || !out_stall;
    assign result_phase = (phase_reg == PH_COUNT) || (phase_reg == PH_CHECK);
    assign in_stall     = pbuf.busy || (result_phase && !out_free);
    assign in_accept    = in_valid && !in_stall;
    assign pos_inc      = pos_reg + 1'b1;
    assign check_acc    = check_reg ^ rx_byte;

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:     phase_next = PH_NODE_HI;
                PH_NODE_HI: phase_next = PH_NODE_LO;
                PH_NODE_LO: phase_next = PH_EP;
                PH_EP:      phase_next = PH_CMD;
                PH_CMD:     phase_next = PH_TYPE;
                PH_TYPE:    phase_next = PH_COUNT;
                PH_COUNT:
                begin
                    if ({1'b0, rx_byte} > COUNT_LIMIT)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (rx_byte == '0)
                    begin
                        phase_next = PH_SEQ;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (BYTE_W'(pos_inc) >= count_reg)
                    begin
                        phase_next = PH_SEQ;
                    end
                end
                PH_SEQ:   phase_next = PH_CHECK;
                PH_CHECK: phase_next = PH_HUNT;
                default:  phase_next = PH_HUNT;
            endcase
        end
    end

    // Field capture, check accumulation and result requests.
    always_comb
    begin
        length_next   = length_reg;
        node_next     = node_reg;
        endpoint_next = endpoint_reg;
        command_next  = command_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        sequence_next = sequence_reg;
        check_next    = check_reg;
        direct_load   = 1'b0;
        direct_status = ST_GOOD;
        buf_wr        = 1'b0;
        buf_start     = 1'b0;
        if (in_accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        check_next    = check_init_reg;
                        length_next   = '0;
                        node_next     = '0;
                        endpoint_next = '0;
                        command_next  = '0;
                        type_next     = '0;
                        count_next    = '0;
                        sequence_next = '0;
                        pos_next      = '0;
                    end
                end
                PH_LEN:
                begin
                    length_next = rx_byte;
                end
                PH_NODE_HI:
                begin
                    node_next  = {rx_byte, {BYTE_W{1'b0}}};
                    check_next = check_acc;
                end
                PH_NODE_LO:
                begin
                    node_next  = {node_reg[NODE_W-1:BYTE_W], rx_byte};
                    check_next = check_acc;
                end
                PH_EP:
                begin
                    endpoint_next = rx_byte;
                    check_next    = check_acc;
                end
                PH_CMD:
                begin
                    command_next = rx_byte;
                    check_next   = check_acc;
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    check_next = check_acc;
                end
                PH_COUNT:
                begin
                    count_next = rx_byte;
                    check_next = check_acc;
                    pos_next   = '0;
                    if ({1'b0, rx_byte} > COUNT_LIMIT)
                    begin
                        direct_load   = 1'b1;
                        direct_status = ST_COUNT_ERR;
                    end
                end
                PH_PAYLOAD:
                begin
                    buf_wr     = 1'b1;
                    check_next = check_acc;
                    pos_next   = pos_inc;
                end
                PH_SEQ:
                begin
                    sequence_next = rx_byte;
                    check_next    = check_acc;
                end
                PH_CHECK:
                begin
                    if (rx_byte != check_reg)
                    begin
                        direct_load   = 1'b1;
                        direct_status = ST_CHECK_ERR;
                    end
                    else if (count_reg == '0)
                    begin
                        direct_load   = 1'b1;
                        direct_status = ST_GOOD;
                    end
                    else
                    begin
                        buf_start = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            length_reg   <= '0;
            node_reg     <= '0;
            endpoint_reg <= '0;
            command_reg  <= '0;
            type_reg     <= '0;
            count_reg    <= '0;
            pos_reg      <= '0;
            sequence_reg <= '0;
            check_reg    <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            node_reg     <= node_next;
            endpoint_reg <= endpoint_next;
            command_reg  <= command_next;
            type_reg     <= type_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            sequence_reg <= sequence_next;
            check_reg    <= check_next;
        end
    end

    assign rd_take = pbuf.valid && out_free;

    sfpx_payload_buf #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_payload_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (buf_wr),
        .wr_addr     (pos_reg[AW-1:0]),
        .wr_data     (rx_byte),
        .start       (buf_start),
        .start_count (CNT_W'(count_reg)),
        .take        (rd_take),
        .rd          (pbuf)
    );

    // Output register: a direct status beat, or one payload beat per cycle while not stalled.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (direct_load || rd_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (direct_load)
        begin
            status_reg          <= direct_status;
            frame_length_reg    <= length_next;
            node_id_reg         <= node_next;
            endpoint_out_reg    <= endpoint_next;
            command_id_reg      <= command_next;
            command_type_reg    <= type_next;
            payload_count_reg   <= count_next;
            sequence_number_reg <= sequence_next;
            payload_byte_reg    <= '0;
            payload_index_reg   <= '0;
            has_payload_reg     <= 1'b0;
            last_reg            <= 1'b1;
        end
        else if (rd_take)
        begin
            status_reg          <= ST_GOOD;
            frame_length_reg    <= length_reg;
            node_id_reg         <= node_reg;
            endpoint_out_reg    <= endpoint_reg;
            command_id_reg      <= command_reg;
            command_type_reg    <= type_reg;
            payload_count_reg   <= count_reg;
            sequence_number_reg <= sequence_reg;
            payload_byte_reg    <= pbuf.data;
            payload_index_reg   <= pbuf.index;
            has_payload_reg     <= 1'b1;
            last_reg            <= pbuf.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign frame_length    = frame_length_reg;
    assign node_id         = node_id_reg;
    assign endpoint        = endpoint_out_reg;
    assign command_id      = command_id_reg;
    assign command_type    = command_type_reg;
    assign payload_count   = payload_count_reg;
    assign sequence_number = sequence_number_reg;
    assign payload_byte    = payload_byte_reg;
    assign payload_index   = payload_index_reg;
    assign has_payload     = has_payload_reg;
    assign last            = last_reg;

    `SFPX_ASSERT_NEVER(a_two_result_sources, direct_load && pbuf.valid)
    `SFPX_ASSERT_IMP(a_payload_in_range, in_accept && (phase_reg == PH_PAYLOAD), BYTE_W'(pos_reg) < count_reg)
    `SFPX_ASSERT_NEXT(a_start_hunts, buf_start, (phase_reg == PH_HUNT) && pbuf.busy)

endmodule

`default_nettype wire

// File: rtl/core/sfpx_payload_buf.sv
// ----------------------------------------------------------------------------
// Serial frame parser payload buffer
// Stores the payload bytes of the frame in flight and, once it checks good,
// reads them back through a registered read stage, one per cycle unless held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_frame_parser_xor_defines.svh"

module sfpx_payload_buf
    import sfpx_pkg::*;
#(
    parameter int PAYLOAD_MAX = 32
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [((PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1)-1:0] wr_addr,
    input  wire logic [BYTE_W-1:0]                     wr_data,
    input  wire logic                                  start,
    input  wire logic [$clog2(PAYLOAD_MAX + 1)-1:0]    start_count,
    input  wire logic                                  take,
    output pbuf_rd_t                                   rd
);

    localparam int AW    = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CNT_W = $clog2(PAYLOAD_MAX + 1);

    logic [BYTE_W-1:0] mem [PAYLOAD_MAX];

    logic              emit_active_reg;
    logic              emit_active_next;
    logic [CNT_W-1:0]  emit_idx_reg;
    logic [CNT_W-1:0]  emit_idx_next;
    logic [CNT_W-1:0]  emit_cnt_reg;
    logic [CNT_W-1:0]  emit_cnt_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [PIDX_W-1:0] rd_index_reg;
    logic              rd_last_reg;
    logic              issue;
    logic              issue_last;
    logic [CNT_W-1:0]  idx_inc;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // While a run is active, a read is issued whenever the read stage is empty or being drained.
    assign issue      = emit_active_reg && (!rd_valid_reg || take);
    assign idx_inc    = emit_idx_reg + 1'b1;
    assign issue_last = (idx_inc == emit_cnt_reg);

    always_comb
    begin
        emit_active_next = emit_active_reg;
        emit_idx_next    = emit_idx_reg;
        emit_cnt_next    = emit_cnt_reg;
        rd_valid_next    = rd_valid_reg;
        if (start)
        begin
            emit_active_next = 1'b1;
            emit_idx_next    = '0;
            emit_cnt_next    = start_count;
        end
        else if (issue)
        begin
            emit_idx_next = idx_inc;
            if (issue_last)
            begin
                emit_active_next = 1'b0;
            end
        end
        if (issue)
        begin
            rd_valid_next = 1'b1;
        end
        else if (take)
        begin
            rd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
            emit_cnt_reg    <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            emit_active_reg <= emit_active_next;
            emit_idx_reg    <= emit_idx_next;
            emit_cnt_reg    <= emit_cnt_next;
            rd_valid_reg    <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg  <= mem[emit_idx_reg[AW-1:0]];
            rd_index_reg <= PIDX_W'(emit_idx_reg);
            rd_last_reg  <= issue_last;
        end
    end

    assign rd.busy  = emit_active_reg || rd_valid_reg;
    assign rd.valid = rd_valid_reg;
    assign rd.data  = rd_data_reg;
    assign rd.index = rd_index_reg;
    assign rd.last  = rd_last_reg;

    `SFPX_ASSERT_NEVER(a_start_while_busy, start && (emit_active_reg || rd_valid_reg))
    `SFPX_ASSERT_IMP(a_start_nonzero, start, start_count != '0)
    `SFPX_ASSERT_IMP(a_last_ends_run, rd_valid_reg && rd_last_reg, !emit_active_reg)

endmodule

`default_nettype wire
